[hdl/assert_macros.svh]
// Assertion macros used by the log table datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("%m: assertion violated");
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: assertion violated");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, expr)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`endif
`endif

[hdl/culog_pkg.sv]
// Shared types and constants of the unstable log table.
package culog_pkg;

   localparam int IDX_W  = 64;
   localparam int OP_W   = 3;
   localparam int STAT_W = 2;

   typedef enum logic [OP_W-1:0] {
      OP_APPEND     = 3'd0,
      OP_FIRST      = 3'd1,
      OP_LAST       = 3'd2,
      OP_TERM       = 3'd3,
      OP_STABLE     = 3'd4,
      OP_SNAPSTABLE = 3'd5,
      OP_RESTORE    = 3'd6,
      OP_SLICE      = 3'd7
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK   = 2'd0,
      ST_NA   = 2'd1,
      ST_OOB  = 2'd2,
      ST_FULL = 2'd3
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic calc;
      logic decide;
      logic stable;
      logic result;
      logic sl_rd;
      logic sl_ld;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic stable_go;
      logic slice_go;
      logic out_free;
      logic slice_last;
   } dp_stat_type;

endpackage

[hdl/culog_if.sv]
// Handshake channel interfaces of the unstable log table.
interface culog_req_if;
   logic                          valid;
   logic                          ready;
   logic [culog_pkg::OP_W-1:0]    op;
   logic [culog_pkg::IDX_W-1:0]   key_index;
   logic [culog_pkg::IDX_W-1:0]   key_term;
   logic [culog_pkg::IDX_W-1:0]   upper_index;
   logic                          first_of_batch;

   modport source (output valid, op, key_index, key_term, upper_index, first_of_batch,
                   input ready);
   modport sink (input valid, op, key_index, key_term, upper_index, first_of_batch,
                 output ready);
endinterface

interface culog_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [culog_pkg::STAT_W-1:0]  status;
   logic [culog_pkg::IDX_W-1:0]   result_index;
   logic [culog_pkg::IDX_W-1:0]   result_term;
   logic                          last;

   modport source (output valid, status, result_index, result_term, last, input ready);
   modport sink (input valid, status, result_index, result_term, last, output ready);
endinterface

interface culog_csr_if;
   logic                          valid;
   logic                          ready;
   logic [culog_pkg::IDX_W-1:0]   data;

   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

[hdl/culog_ctrl.sv]
// Controller state machine of the unstable log table.
module culog_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  culog_pkg::dp_stat_type stat,
   output culog_pkg::dp_cmd_type  cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_DECIDE,
      S_STABLE,
      S_RESULT,
      S_SL_RD,
      S_SL_LD
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_CALC;
            end
            S_CALC: begin
               state_ff <= S_DECIDE;
            end
            S_DECIDE: begin
               if (stat.stable_go)     state_ff <= S_STABLE;
               else if (stat.slice_go) state_ff <= S_SL_RD;
               else                    state_ff <= S_RESULT;
            end
            S_STABLE: begin
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               if (stat.out_free) state_ff <= S_IDLE;
            end
            S_SL_RD: begin
               state_ff <= S_SL_LD;
            end
            S_SL_LD: begin
               if (stat.out_free) state_ff <= stat.slice_last ? S_IDLE : S_SL_RD;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd         = '0;
      cmd.capture = (state_ff == S_IDLE) && req_valid;
      cmd.calc    = (state_ff == S_CALC);
      cmd.decide  = (state_ff == S_DECIDE);
      cmd.stable  = (state_ff == S_STABLE);
      cmd.result  = (state_ff == S_RESULT);
      cmd.sl_rd   = (state_ff == S_SL_RD);
      cmd.sl_ld   = (state_ff == S_SL_LD);
   end

endmodule

[hdl/culog_dp.sv]
// Datapath of the unstable log table: log state, term ring and result register.
`include "assert_macros.svh"
module culog_dp #(
   parameter int RING_DEPTH = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  culog_pkg::dp_cmd_type               cmd,
   output culog_pkg::dp_stat_type              stat,
   input  logic [culog_pkg::OP_W-1:0]          req_op,
   input  logic [culog_pkg::IDX_W-1:0]         req_key_index,
   input  logic [culog_pkg::IDX_W-1:0]         req_key_term,
   input  logic [culog_pkg::IDX_W-1:0]         req_upper_index,
   input  logic                                req_first_of_batch,
   input  logic                                csr_valid,
   input  logic [culog_pkg::IDX_W-1:0]         csr_data,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [culog_pkg::STAT_W-1:0]        rsp_status,
   output logic [culog_pkg::IDX_W-1:0]         rsp_result_index,
   output logic [culog_pkg::IDX_W-1:0]         rsp_result_term,
   output logic                                rsp_last
);

   localparam int IW = culog_pkg::IDX_W;
   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CW = $clog2(RING_DEPTH + 1);
   localparam logic [CW:0]   DEPTH_W = (CW+1)'(RING_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(RING_DEPTH);
   localparam logic [AW-1:0] SLOT_MAX = AW'(RING_DEPTH - 1);

   // Ring slot of a position counted from the head; the slot is right only for pos up to the depth.
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] head,
                                             input logic [CW-1:0] pos);
      logic [CW:0] sum;
      sum = (CW+1)'(head) + {1'b0, pos};
      if (sum >= DEPTH_W) sum = sum - DEPTH_W;
      return sum[AW-1:0];
   endfunction

   // Captured request
   culog_pkg::op_type op_ff;
   logic [IW-1:0]     ki_ff, kt_ff, hi_ff;
   logic              fob_ff;

   // Precomputed compares
   logic [IW-1:0]     diff_ff, hdiff_ff;
   logic              ki_lt_first_ff, ki_gt_hi_ff, ki_eq_snap_ff, ki_eq_hi_ff;
   logic [IW:0]       diff_w;

   // Log state
   logic [AW-1:0]     head_ff, head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     first_ff, first_in;
   logic              snap_valid_ff, snap_valid_in;
   logic [IW-1:0]     snap_index_ff, snap_index_in;
   logic [IW-1:0]     snap_term_ff, snap_term_in;

   // Term ring
   logic [IW-1:0]     ring [RING_DEPTH];
   logic [IW-1:0]     mem_rd_ff;
   logic [AW-1:0]     rd_addr, wr_addr;
   logic              rd_en, wr_en;

   // Pending single result
   culog_pkg::status_type res_status_ff, res_status_in;
   logic [IW-1:0]     res_base_ff, res_base_in;
   logic [CW-1:0]     res_off_ff, res_off_in;
   logic [IW-1:0]     res_term_ff, res_term_in;
   logic              res_term_mem_ff, res_term_mem_in;

   // Slice walk
   logic [CW-1:0]     pos_ff, pos_in, end_ff, end_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic [IW-1:0]     idx_ff, idx_in;

   // Output register
   logic              out_valid_ff, out_valid_in;
   culog_pkg::status_type out_status_ff, out_status_in;
   logic [IW-1:0]     out_index_ff, out_index_in;
   logic [IW-1:0]     out_term_ff, out_term_in;
   logic              out_last_ff, out_last_in;

   // Decision terms
   logic              diff_small, hdiff_small;
   logic [CW-1:0]     diff_n, hdiff_n, diff_n1, cnt_eff;
   logic [IW-1:0]     first_eff;
   logic              in_ring, snap_hit, app_match, app_reset, app_redo;
   logic              app_oob, app_full, slice_err, out_free, slice_last;

   assign diff_small  = (diff_ff[IW-1:CW] == '0);
   assign hdiff_small = (hdiff_ff[IW-1:CW] == '0);
   assign diff_n      = diff_ff[CW-1:0];
   assign hdiff_n     = hdiff_ff[CW-1:0];
   assign diff_n1     = diff_n + CW'(1);

   assign in_ring   = !ki_lt_first_ff && diff_small && (diff_n < count_ff);
   assign snap_hit  = ki_lt_first_ff && snap_valid_ff && ki_eq_snap_ff;
   assign app_match = diff_small && (diff_n == count_ff);
   assign app_reset = ki_lt_first_ff || (diff_ff == '0);
   assign app_redo  = fob_ff && !app_match;
   assign app_oob   = app_redo && !app_reset && (!diff_small || (diff_n > count_ff));
   assign cnt_eff   = app_redo ? (app_reset ? '0 : diff_n) : count_ff;
   assign first_eff = (app_redo && app_reset) ? ki_ff : first_ff;
   assign app_full  = (cnt_eff >= DEPTH_C);
   assign slice_err = ki_gt_hi_ff || ki_lt_first_ff || !hdiff_small || (hdiff_n > count_ff);

   assign out_free   = !out_valid_ff || rsp_ready;
   assign slice_last = (({1'b0, pos_ff} + (CW+1)'(1)) == {1'b0, end_ff});

   always_comb begin
      stat            = '0;
      stat.stable_go  = (op_ff == culog_pkg::OP_STABLE) && in_ring;
      stat.slice_go   = (op_ff == culog_pkg::OP_SLICE) && !slice_err && !ki_eq_hi_ff;
      stat.out_free   = out_free;
      stat.slice_last = slice_last;
   end

   assign diff_w = {1'b0, ki_ff} - {1'b0, first_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= culog_pkg::op_type'(req_op);
         ki_ff  <= req_key_index;
         kt_ff  <= req_key_term;
         hi_ff  <= req_upper_index;
         fob_ff <= req_first_of_batch;
      end
      if (cmd.calc) begin
         diff_ff        <= diff_w[IW-1:0];
         ki_lt_first_ff <= diff_w[IW];
         hdiff_ff       <= hi_ff - first_ff;
         ki_gt_hi_ff    <= (ki_ff > hi_ff);
         ki_eq_snap_ff  <= (ki_ff == snap_index_ff);
         ki_eq_hi_ff    <= (ki_ff == hi_ff);
      end
   end

   // Ring port: one write, one registered read
   assign rd_addr = cmd.sl_rd ? slot_ff : slot_of(head_ff, diff_n);
   assign rd_en   = cmd.decide || cmd.sl_rd;
   assign wr_addr = slot_of(head_ff, cnt_eff);
   assign wr_en   = cmd.decide && (op_ff == culog_pkg::OP_APPEND) && !app_oob && !app_full;

   always_ff @(posedge clock) begin
      if (wr_en) ring[wr_addr] <= kt_ff;
      if (rd_en) mem_rd_ff <= ring[rd_addr];
   end

   always_comb begin
      head_in         = head_ff;
      count_in        = count_ff;
      first_in        = first_ff;
      snap_valid_in   = snap_valid_ff;
      snap_index_in   = snap_index_ff;
      snap_term_in    = snap_term_ff;
      res_status_in   = res_status_ff;
      res_base_in     = res_base_ff;
      res_off_in      = res_off_ff;
      res_term_in     = res_term_ff;
      res_term_mem_in = res_term_mem_ff;
      pos_in          = pos_ff;
      end_in          = end_ff;
      slot_in         = slot_ff;
      idx_in          = idx_ff;
      out_valid_in    = out_valid_ff;
      out_status_in   = out_status_ff;
      out_index_in    = out_index_ff;
      out_term_in     = out_term_ff;
      out_last_in     = out_last_ff;

      if (cmd.decide) begin
         res_status_in   = culog_pkg::ST_NA;
         res_base_in     = '0;
         res_off_in      = '0;
         res_term_in     = '0;
         res_term_mem_in = 1'b0;
         case (op_ff)
            culog_pkg::OP_APPEND: begin
               if (app_oob) begin
                  res_status_in = culog_pkg::ST_OOB;
               end else if (app_full) begin
                  res_status_in = culog_pkg::ST_FULL;
               end else begin
                  count_in      = cnt_eff + CW'(1);
                  first_in      = first_eff;
                  res_status_in = culog_pkg::ST_OK;
                  res_base_in   = first_eff;
                  res_off_in    = cnt_eff;
                  res_term_in   = kt_ff;
               end
            end
            culog_pkg::OP_FIRST: begin
               if (snap_valid_ff) begin
                  res_status_in = culog_pkg::ST_OK;
                  res_base_in   = snap_index_ff;
                  res_off_in    = CW'(1);
               end
            end
            culog_pkg::OP_LAST: begin
               if (count_ff != '0) begin
                  res_status_in = culog_pkg::ST_OK;
                  res_base_in   = first_ff;
                  res_off_in    = count_ff - CW'(1);
               end else if (snap_valid_ff) begin
                  res_status_in = culog_pkg::ST_OK;
                  res_base_in   = snap_index_ff;
               end
            end
            culog_pkg::OP_TERM: begin
               if (in_ring) begin
                  res_status_in   = culog_pkg::ST_OK;
                  res_base_in     = ki_ff;
                  res_term_mem_in = 1'b1;
               end else if (snap_hit) begin
                  res_status_in = culog_pkg::ST_OK;
                  res_base_in   = ki_ff;
                  res_term_in   = snap_term_ff;
               end
            end
            culog_pkg::OP_STABLE: begin
               // term check follows once the ring read returns
            end
            culog_pkg::OP_SNAPSTABLE: begin
               if (snap_valid_ff && ki_eq_snap_ff) begin
                  snap_valid_in = 1'b0;
                  res_status_in = culog_pkg::ST_OK;
               end
            end
            culog_pkg::OP_RESTORE: begin
               count_in      = '0;
               first_in      = ki_ff + IW'(1);
               snap_valid_in = 1'b1;
               snap_index_in = ki_ff;
               snap_term_in  = kt_ff;
               res_status_in = culog_pkg::ST_OK;
            end
            culog_pkg::OP_SLICE: begin
               if (slice_err) begin
                  res_status_in = culog_pkg::ST_OOB;
               end else if (ki_eq_hi_ff) begin
                  res_base_in = ki_ff;
               end else begin
                  pos_in  = diff_n;
                  end_in  = hdiff_n;
                  slot_in = slot_of(head_ff, diff_n);
                  idx_in  = ki_ff;
               end
            end
            default: begin
               res_status_in = culog_pkg::ST_NA;
            end
         endcase
      end

      if (cmd.stable) begin
         if (mem_rd_ff == kt_ff) begin
            head_in       = slot_of(head_ff, diff_n1);
            count_in      = count_ff - diff_n1;
            first_in      = ki_ff + IW'(1);
            res_status_in = culog_pkg::ST_OK;
         end
      end

      // Drop the shown result when taken, then load a new one if due
      if (out_valid_ff && rsp_ready) out_valid_in = 1'b0;
      if (cmd.result && out_free) begin
         out_valid_in  = 1'b1;
         out_status_in = res_status_ff;
         out_index_in  = res_base_ff + IW'(res_off_ff);
         out_term_in   = res_term_mem_ff ? mem_rd_ff : res_term_ff;
         out_last_in   = 1'b1;
      end
      if (cmd.sl_ld && out_free) begin
         out_valid_in  = 1'b1;
         out_status_in = culog_pkg::ST_OK;
         out_index_in  = idx_ff;
         out_term_in   = mem_rd_ff;
         out_last_in   = slice_last;
         pos_in        = pos_ff + CW'(1);
         idx_in        = idx_ff + IW'(1);
         slot_in       = (slot_ff == SLOT_MAX) ? '0 : slot_ff + AW'(1);
      end

      // A register write reopens the log at the written index
      if (csr_valid) begin
         head_in       = '0;
         count_in      = '0;
         first_in      = csr_data;
         snap_valid_in = 1'b0;
         snap_index_in = '0;
         snap_term_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         first_ff      <= '0;
         snap_valid_ff <= 1'b0;
         snap_index_ff <= '0;
         snap_term_ff  <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         first_ff      <= first_in;
         snap_valid_ff <= snap_valid_in;
         snap_index_ff <= snap_index_in;
         snap_term_ff  <= snap_term_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_status_ff   <= res_status_in;
      res_base_ff     <= res_base_in;
      res_off_ff      <= res_off_in;
      res_term_ff     <= res_term_in;
      res_term_mem_ff <= res_term_mem_in;
      pos_ff          <= pos_in;
      end_ff          <= end_in;
      slot_ff         <= slot_in;
      idx_ff          <= idx_in;
      out_status_ff   <= out_status_in;
      out_index_ff    <= out_index_in;
      out_term_ff     <= out_term_in;
      out_last_ff     <= out_last_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_status       = out_status_ff;
   assign rsp_result_index = out_index_ff;
   assign rsp_result_term  = out_term_ff;
   assign rsp_last         = out_last_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= DEPTH_C)
   `ASSERT_ALWAYS(a_head_bound, clock, reset, (CW+1)'(head_ff) < DEPTH_W)
   `ASSERT_IMPLY(a_write_room, clock, reset, wr_en, cnt_eff < DEPTH_C)
   `ASSERT_IMPLY(a_slice_pos, clock, reset, cmd.sl_ld, pos_ff < end_ff)
   `ASSERT_IMPLY(a_mid_ok, clock, reset, out_valid_ff && !out_last_ff, out_status_ff == 0)

endmodule

[hdl/consensus_unstable_log_table.sv]
// Top level of the unstable log table: request, response and register channels.
// A single-result request is captured, compared, decided (stable-to: term check) and then loaded
// into the output register; a slice reads each entry from the ring, then loads it, in turn.
// A new request is accepted only once the last one is loaded; a busy output register stalls the load.
// Reset (synchronous, active high): log empty at first index 0, snapshot dropped, no response
// pending; ring contents stay undefined and need no clearing pass.
module consensus_unstable_log_table #(
   parameter int RING_DEPTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   culog_req_if.sink   req_chan,
   culog_rsp_if.source rsp_chan,
   culog_csr_if.sink   csr_chan
);

   culog_pkg::dp_cmd_type  cmd;
   culog_pkg::dp_stat_type stat;

   // Register writes are always taken; they must come only while the table is idle, unchecked.
   assign csr_chan.ready = 1'b1;

   // Sequencer: accept a request, compare, decide, then load the result
   // (or walk the slice one entry at a time).
   culog_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Log state, ring memory and output register. The output register holds a
   // finished response while the next request is accepted.
   culog_dp #(
      .RING_DEPTH (RING_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_op             (req_chan.op),
      .req_key_index      (req_chan.key_index),
      .req_key_term       (req_chan.key_term),
      .req_upper_index    (req_chan.upper_index),
      .req_first_of_batch (req_chan.first_of_batch),
      .csr_valid          (csr_chan.valid),
      .csr_data           (csr_chan.data),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_status         (rsp_chan.status),
      .rsp_result_index   (rsp_chan.result_index),
      .rsp_result_term    (rsp_chan.result_term),
      .rsp_last           (rsp_chan.last)
   );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for the unstable log table: directed and random requests.
`timescale 1ns / 1ps

module tb;

   localparam int RING_DEPTH = 32;
   // Generous cycle budget for the whole run.
   localparam int CYCLE_LIMIT = 200000;

   typedef struct {
      culog_pkg::op_type op;
      logic [63:0]       key_index;
      logic [63:0]       key_term;
      logic [63:0]       upper_index;
      logic              first_of_batch;
   } log_request_type;

   typedef struct {
      culog_pkg::status_type status;
      logic [63:0]           index;
      logic [63:0]           term;
      logic                  last;
   } log_reply_type;

   // Scoreboard: tracks the log tail and the replies the block still owes.
   class log_tail_checker #(int DEPTH = 32);
      logic [63:0]    ring_terms [DEPTH];
      int unsigned    head;
      int unsigned    held;
      logic [63:0]    base_index;
      logic [63:0]    start_offset;
      bit             snap_on;
      logic [63:0]    snap_idx;
      logic [63:0]    snap_trm;
      log_reply_type  owed_replies[$];
      int unsigned    errors;

      function new();
         errors = 0;
         restart(64'd0);
      endfunction

      // Register write: reinitialize the log at the given first index.
      function void restart(logic [63:0] value);
         start_offset = value;
         head = 0;
         held = 0;
         base_index = value;
         snap_on = 1'b0;
         snap_idx = '0;
         snap_trm = '0;
      endfunction

      function int unsigned owed();
         return owed_replies.size();
      endfunction

      function void owe(culog_pkg::status_type st, logic [63:0] idx, logic [63:0] trm,
                        logic fin);
         log_reply_type r;
         r.status = st;
         r.index = idx;
         r.term = trm;
         r.last = fin;
         owed_replies.push_back(r);
      endfunction

      function bit term_at(logic [63:0] idx, output logic [63:0] trm);
         trm = '0;
         if (idx < base_index) begin
            if (snap_on && snap_idx == idx) begin
               trm = snap_trm;
               return 1'b1;
            end
            return 1'b0;
         end
         if (idx - base_index >= 64'(held))
            return 1'b0;
         trm = ring_terms[(head + 32'(idx - base_index)) % DEPTH];
         return 1'b1;
      endfunction

      // Apply one accepted request and queue the replies it causes.
      function void note_request(log_request_type r);
         logic [63:0] t;
         int unsigned drop;
         int unsigned lo;
         int unsigned up;
         case (r.op)
            culog_pkg::OP_APPEND: begin
               if (r.first_of_batch && r.key_index != base_index + 64'(held)) begin
                  if (r.key_index <= base_index) begin
                     base_index = r.key_index;
                     held = 0;
                  end else if (r.key_index - base_index > 64'(held)) begin
                     owe(culog_pkg::ST_OOB, '0, '0, 1'b1);
                     return;
                  end else begin
                     held = 32'(r.key_index - base_index);
                  end
               end
               if (held >= DEPTH) begin
                  owe(culog_pkg::ST_FULL, '0, '0, 1'b1);
                  return;
               end
               ring_terms[(head + held) % DEPTH] = r.key_term;
               held++;
               owe(culog_pkg::ST_OK, base_index + 64'(held) - 64'd1, r.key_term, 1'b1);
            end
            culog_pkg::OP_FIRST: begin
               if (snap_on)
                  owe(culog_pkg::ST_OK, snap_idx + 64'd1, '0, 1'b1);
               else
                  owe(culog_pkg::ST_NA, '0, '0, 1'b1);
            end
            culog_pkg::OP_LAST: begin
               if (held != 0)
                  owe(culog_pkg::ST_OK, base_index + 64'(held) - 64'd1, '0, 1'b1);
               else if (snap_on)
                  owe(culog_pkg::ST_OK, snap_idx, '0, 1'b1);
               else
                  owe(culog_pkg::ST_NA, '0, '0, 1'b1);
            end
            culog_pkg::OP_TERM: begin
               if (term_at(r.key_index, t))
                  owe(culog_pkg::ST_OK, r.key_index, t, 1'b1);
               else
                  owe(culog_pkg::ST_NA, '0, '0, 1'b1);
            end
            culog_pkg::OP_STABLE: begin
               if (term_at(r.key_index, t) && t == r.key_term &&
                   r.key_index >= base_index) begin
                  drop = 32'(r.key_index - base_index) + 1;
                  head = (head + drop) % DEPTH;
                  held = held - drop;
                  base_index = r.key_index + 64'd1;
                  owe(culog_pkg::ST_OK, '0, '0, 1'b1);
               end else begin
                  owe(culog_pkg::ST_NA, '0, '0, 1'b1);
               end
            end
            culog_pkg::OP_SNAPSTABLE: begin
               if (snap_on && snap_idx == r.key_index) begin
                  snap_on = 1'b0;
                  owe(culog_pkg::ST_OK, '0, '0, 1'b1);
               end else begin
                  owe(culog_pkg::ST_NA, '0, '0, 1'b1);
               end
            end
            culog_pkg::OP_RESTORE: begin
               held = 0;
               base_index = r.key_index + 64'd1;
               snap_on = 1'b1;
               snap_idx = r.key_index;
               snap_trm = r.key_term;
               owe(culog_pkg::ST_OK, '0, '0, 1'b1);
            end
            culog_pkg::OP_SLICE: begin
               if (r.key_index > r.upper_index || r.key_index < base_index ||
                   r.upper_index - base_index > 64'(held)) begin
                  owe(culog_pkg::ST_OOB, '0, '0, 1'b1);
               end else if (r.key_index == r.upper_index) begin
                  owe(culog_pkg::ST_NA, r.key_index, '0, 1'b1);
               end else begin
                  lo = 32'(r.key_index - base_index);
                  up = 32'(r.upper_index - base_index);
                  for (int unsigned i = lo; i < up; i++)
                     owe(culog_pkg::ST_OK, base_index + 64'(i),
                         ring_terms[(head + i) % DEPTH], i + 1 == up);
               end
            end
            default: begin
               owe(culog_pkg::ST_NA, '0, '0, 1'b1);
            end
         endcase
      endfunction

      task report_mismatch(string msg);
         $display("[%0t] mismatch: %s", $time, msg);
         errors++;
      endtask

      // Compare one accepted reply with the oldest owed one.
      task check_response(logic [1:0] st, logic [63:0] idx, logic [63:0] trm, logic fin);
         log_reply_type want;
         if (owed_replies.size() == 0) begin
            report_mismatch($sformatf("unexpected reply status %0d index %0h", st, idx));
            return;
         end
         want = owed_replies.pop_front();
         if (st !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", st, want.status));
         if (idx !== want.index)
            report_mismatch($sformatf("result_index %0h, want %0h", idx, want.index));
         if (trm !== want.term)
            report_mismatch($sformatf("result_term %0h, want %0h", trm, want.term));
         if (fin !== want.last)
            report_mismatch($sformatf("last %0b, want %0b", fin, want.last));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   steady = 1'b0;   // when set, neither side stalls at random
   int   cycle_count = 0;

   log_tail_checker #(RING_DEPTH) sb;

   culog_req_if req_if();
   culog_rsp_if rsp_if();
   culog_csr_if csr_if();

   consensus_unstable_log_table #(.RING_DEPTH(RING_DEPTH)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Bound the run; a hang counts as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // Stall the reply channel at random, with a chance of about 8 percent, unless steady.
   always @(posedge clock) begin
      rsp_if.ready <= steady || ($urandom_range(99) >= 8);
   end

   // Check every reply accepted at this edge against the oldest owed one.
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_response(rsp_if.status, rsp_if.result_index, rsp_if.result_term,
                           rsp_if.last);
   end

   // Present one request, hold it until accepted, then record it.
   // Valid stays high on return so back-to-back requests need no toggle.
   task automatic send_request(input log_request_type r);
      if (!steady && $urandom_range(99) < 8) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(6, 1)) @(posedge clock);
      end
      req_if.valid          <= 1'b1;
      req_if.op             <= r.op;
      req_if.key_index      <= r.key_index;
      req_if.key_term       <= r.key_term;
      req_if.upper_index    <= r.upper_index;
      req_if.first_of_batch <= r.first_of_batch;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      sb.note_request(r);
   endtask

   task automatic issue(input culog_pkg::op_type op, input logic [63:0] ki,
                        input logic [63:0] kt, input logic [63:0] hi, input logic fob);
      log_request_type r;
      r.op = op;
      r.key_index = ki;
      r.key_term = kt;
      r.upper_index = hi;
      r.first_of_batch = fob;
      send_request(r);
   endtask

   // Drop valid and hold off until every owed reply has come back.
   task automatic drain_replies();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.owed() != 0) @(posedge clock);
   endtask

   // Write the first index register while the block is idle.
   task automatic write_start_offset(input logic [63:0] value);
      drain_replies();
      csr_if.valid <= 1'b1;
      csr_if.data  <= value;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
      sb.restart(value);
   endtask

   // Random request biased toward the held range so that appends build up
   // real tails and lookups, stable-to and slices mostly hit live entries.
   function automatic log_request_type make_random_request();
      log_request_type r;
      logic [63:0]     tail;
      logic [63:0]     t;
      int unsigned     pick;
      int unsigned     lo;
      int unsigned     span;
      tail = sb.base_index + 64'(sb.held);
      r.op = culog_pkg::op_type'($urandom_range(7));
      r.key_index = {$urandom, $urandom};
      r.key_term = {$urandom, $urandom};
      r.upper_index = {$urandom, $urandom};
      r.first_of_batch = $urandom_range(1);
      pick = $urandom_range(99);
      if (pick < 10)
         return r;   // noise: any field values at all
      if (pick < 45) begin
         r.op = culog_pkg::OP_APPEND;
         r.first_of_batch = ($urandom_range(3) == 0);
         if ($urandom_range(1) == 0)
            r.key_term = 64'($urandom_range(50));
         if (r.first_of_batch)
            r.key_index = tail + 64'($urandom_range(4)) - 64'd2;
      end else if (pick < 55) begin
         r.op = culog_pkg::OP_TERM;
         if (sb.snap_on && $urandom_range(4) == 0)
            r.key_index = sb.snap_idx;
         else
            r.key_index = sb.base_index + 64'($urandom_range(sb.held + 1)) - 64'd1;
      end else if (pick < 63) begin
         r.op = culog_pkg::OP_STABLE;
         if (sb.snap_on && $urandom_range(4) == 0)
            r.key_index = sb.snap_idx;
         else
            r.key_index = sb.base_index + 64'($urandom_range(sb.held));
         if (sb.term_at(r.key_index, t) && $urandom_range(3) != 0)
            r.key_term = t;
      end else if (pick < 68) begin
         r.op = culog_pkg::OP_SNAPSTABLE;
         r.key_index = sb.snap_idx + 64'($urandom_range(1));
      end else if (pick < 72) begin
         r.op = culog_pkg::OP_RESTORE;
         if ($urandom_range(1) == 0)
            r.key_index = tail + 64'($urandom_range(8));
      end else if (pick < 78) begin
         r.op = ($urandom_range(1) == 0) ? culog_pkg::OP_FIRST : culog_pkg::OP_LAST;
      end else begin
         r.op = culog_pkg::OP_SLICE;
         lo = $urandom_range(sb.held);
         span = $urandom_range(sb.held - lo);
         r.key_index = sb.base_index + 64'(lo);
         r.upper_index = r.key_index + 64'(span);
         if ($urandom_range(9) == 0)
            r.upper_index = r.upper_index + 64'd1;   // one past the tail at times
         if ($urandom_range(9) == 0)
            r.key_index = r.key_index - 64'd1;       // one below the first index
      end
      return r;
   endfunction

   task automatic run_random_phase(input logic [63:0] offset, input int count);
      write_start_offset(offset);
      repeat (count) begin
         // Now and then hold off until every owed reply is back.
         if ($urandom_range(14) == 0)
            drain_replies();
         send_request(make_random_request());
      end
   endtask

   // Fill the ring to overflow, slice all of it, then release it all.
   task automatic run_fill_phase();
      logic [63:0] t;
      write_start_offset(64'h8000_0000_0000_0000);
      repeat (RING_DEPTH + 1)
         issue(culog_pkg::OP_APPEND, '0, {$urandom, $urandom}, '0, 1'b0);
      issue(culog_pkg::OP_APPEND, sb.base_index + 64'(sb.held), 64'd1, '0, 1'b1);
      issue(culog_pkg::OP_SLICE, sb.base_index, '0, sb.base_index + 64'(sb.held), 1'b0);
      void'(sb.term_at(sb.base_index + 64'(RING_DEPTH - 1), t));
      issue(culog_pkg::OP_STABLE, sb.base_index + 64'(RING_DEPTH - 1), t, '0, 1'b0);
      issue(culog_pkg::OP_LAST, '0, '0, '0, 1'b0);
   endtask

   task automatic run_directed();
      // empty log after reset: nothing known
      issue(culog_pkg::OP_FIRST, '0, '0, '0, 1'b0);
      issue(culog_pkg::OP_LAST, '1, '1, '1, 1'b1);
      issue(culog_pkg::OP_TERM, '1, '0, '0, 1'b0);
      issue(culog_pkg::OP_SLICE, '0, '0, '0, 1'b0);          // empty slice
      issue(culog_pkg::OP_SNAPSTABLE, '0, '0, '0, 1'b0);     // no snapshot held
      // batch appends: tail, ignored indices, beyond tail, truncate, exact tail
      issue(culog_pkg::OP_APPEND, 64'd0, '1, '0, 1'b1);
      issue(culog_pkg::OP_APPEND, '1, 64'd5, '1, 1'b0);
      issue(culog_pkg::OP_APPEND, 64'd77, 64'd0, '0, 1'b0);
      issue(culog_pkg::OP_APPEND, 64'd5, 64'd6, '0, 1'b1);
      issue(culog_pkg::OP_APPEND, 64'd2, 64'd7, '0, 1'b1);
      issue(culog_pkg::OP_APPEND, 64'd3, 64'd8, '0, 1'b1);
      issue(culog_pkg::OP_TERM, 64'd1, '0, '0, 1'b0);
      issue(culog_pkg::OP_SLICE, 64'd1, '0, 64'd4, 1'b0);
      issue(culog_pkg::OP_SLICE, 64'd3, '0, 64'd2, 1'b0);    // reversed bounds
      issue(culog_pkg::OP_SLICE, 64'd0, '0, 64'd5, 1'b0);    // past the tail
      // stable-to: wrong term, then a match
      issue(culog_pkg::OP_STABLE, 64'd1, 64'd4, '0, 1'b0);
      issue(culog_pkg::OP_STABLE, 64'd1, 64'd5, '0, 1'b0);
      issue(culog_pkg::OP_LAST, '0, '0, '0, 1'b0);
      // snapshot: restore, query, stable-to below the first index, release
      issue(culog_pkg::OP_RESTORE, 64'd100, 64'd9, '0, 1'b0);
      issue(culog_pkg::OP_FIRST, '0, '0, '0, 1'b0);
      issue(culog_pkg::OP_LAST, '0, '0, '0, 1'b0);
      issue(culog_pkg::OP_TERM, 64'd100, '0, '0, 1'b0);
      issue(culog_pkg::OP_STABLE, 64'd100, 64'd9, '0, 1'b0);
      issue(culog_pkg::OP_SNAPSTABLE, 64'd99, '0, '0, 1'b0);
      issue(culog_pkg::OP_SNAPSTABLE, 64'd100, '0, '0, 1'b0);
      // batch opening at or below the first index replaces every held entry
      issue(culog_pkg::OP_APPEND, 64'd50, 64'd3, '0, 1'b1);
   endtask

   initial begin
      reset                 <= 1'b1;
      req_if.valid          <= 1'b0;
      req_if.op             <= culog_pkg::OP_APPEND;
      req_if.key_index      <= '0;
      req_if.key_term       <= '0;
      req_if.upper_index    <= '0;
      req_if.first_of_batch <= 1'b0;
      csr_if.valid          <= 1'b0;
      csr_if.data           <= '0;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      run_directed();

      // Run the overflow phase and one random phase with no random stalls on either channel.
      steady = 1'b1;
      run_fill_phase();
      run_random_phase('1, 10);
      steady = 1'b0;

      run_random_phase({$urandom, $urandom}, 10);
      run_random_phase(64'd0, 10);
      run_random_phase(64'hFFFF_FFFF_FFFF_FFF8, 10);

      // Wait out the owed replies, then watch for strays a little longer.
      drain_replies();
      repeat (16) @(posedge clock);

      if (sb.errors == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
